FILE: sv/fpba_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// fit-policy block allocator. No dependencies.
package fpba_pkg;

  // Table geometry
  localparam int NUM_BLOCKS = 8;
  localparam int SIZE_BITS  = 24;
  localparam int IDX_W      = 3;   // block_index / chosen_block field width
  localparam int NB_W       = 4;   // num_blocks register width
  localparam int CFG_AW     = 3;   // two 32-bit registers at byte 0 and 4

  // Policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  // Item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  // Register indexes (paddr[2])
  localparam logic REG_POLICY     = 1'b0;
  localparam logic REG_NUM_BLOCKS = 1'b1;

  localparam logic [NB_W-1:0] NB_RESET = NB_W'(NUM_BLOCKS);

  typedef logic [SIZE_BITS-1:0] cap_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_in;  // capture item, set up scan
    logic step;     // examine one table entry
    logic commit;   // write back and present result
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_alloc;  // item on the input ports is an allocate
    logic empty;     // no blocks in use
    logic stop;      // current entry ends the search
    logic last;      // current entry is the last one to examine
  } stat_t;

endpackage

FILE: sv/fit_policy_block_allocator_unit.sv
// Top level of the fit-policy block allocator: register port, controller
// and datapath. Depends on fpba_pkg, fpba_ctrl and fpba_dp.
//
//  channel   handshake               payload
//  --------  ----------------------  -------------------------------------------
//  input     start & !busy           in_func, in_block_index, in_amount
//  result    out_valid (one cycle)   out_granted, out_chosen_block, out_remaining
//  config    psel&penable&pwrite     paddr, pwdata -> policy, num_blocks
//
// A load item goes from accept through the commit state to the result strobe. An
// allocate item also passes through the scan state, where the scan unit examines
// k table entries, one entry per cycle (k <= num_blocks in use; first fit and
// next fit stop at the first fitting entry). With no blocks in use it skips the scan.
// busy drops in the cycle the result is shown, so the next item may start then.
// Reset (rst_n low, synchronous) zeroes the capacity table and rover and loads
// policy = first fit, num_blocks = 8. The receiver cannot stall: each result
// is shown for exactly one cycle.
module fit_policy_block_allocator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // item channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_func,
  input  logic [fpba_pkg::IDX_W-1:0]     in_block_index,
  input  logic [fpba_pkg::SIZE_BITS-1:0] in_amount,
  // result channel
  output logic                           out_valid,
  output logic                           out_granted,
  output logic [fpba_pkg::IDX_W-1:0]     out_chosen_block,
  output logic [fpba_pkg::SIZE_BITS-1:0] out_remaining,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fpba_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import fpba_pkg::*;

  logic [1:0]      cfg_policy_r;
  logic [NB_W-1:0] cfg_num_blocks_r;
  logic            cfg_wr;
  logic            cfg_sel;

  cmd_t  cmd;
  stat_t stat;

  // Register port: zero wait states, word index in paddr[2]
  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_policy_r     <= POL_FIRST;
      cfg_num_blocks_r <= NB_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_POLICY:     cfg_policy_r     <= pwdata[1:0];
        REG_NUM_BLOCKS: cfg_num_blocks_r <= pwdata[NB_W-1:0];
        default:        cfg_policy_r     <= cfg_policy_r;
      endcase
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    unique case (cfg_sel)
      REG_POLICY:     prdata = 32'(cfg_policy_r);
      REG_NUM_BLOCKS: prdata = 32'(cfg_num_blocks_r);
      default:        prdata = '0;
    endcase
  end

  // Sequence accept, scan and commit
  fpba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the table, run the scan, produce the result
  fpba_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_block_index   (in_block_index),
    .in_amount        (in_amount),
    .policy           (cfg_policy_r),
    .num_blocks       (cfg_num_blocks_r),
    .out_valid        (out_valid),
    .out_granted      (out_granted),
    .out_chosen_block (out_chosen_block),
    .out_remaining    (out_remaining)
  );

  // A result only follows a cycle in which an item was in flight
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in flight");

  // An accepted item makes the block busy
  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but busy not raised");

  // One strobe per item: never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A refused request reports block 0 and nothing remaining
  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_chosen_block == '0 && out_remaining == '0))
    else $error("refused request carries nonzero payload");

endmodule

FILE: sv/fpba_ctrl.sv
// Sequencer for the block allocator: accept, scan, commit.
// Depends on fpba_pkg.
module fpba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  fpba_pkg::stat_t stat,
  output fpba_pkg::cmd_t  cmd,
  output logic           busy
);
  import fpba_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.load_in = 1'b0;
    cmd.step    = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          if (stat.in_alloc && !stat.empty) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.stop || stat.last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

FILE: sv/fpba_dp.sv
// Datapath of the block allocator: capacity table, scan pointer, best-candidate
// tracking, rover and result registers. Depends on fpba_pkg.
module fpba_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fpba_pkg::cmd_t                 cmd,
  output fpba_pkg::stat_t                stat,
  input  logic                           in_func,
  input  logic [fpba_pkg::IDX_W-1:0]     in_block_index,
  input  logic [fpba_pkg::SIZE_BITS-1:0] in_amount,
  input  logic [1:0]                     policy,
  input  logic [fpba_pkg::NB_W-1:0]      num_blocks,
  output logic                           out_valid,
  output logic                           out_granted,
  output logic [fpba_pkg::IDX_W-1:0]     out_chosen_block,
  output logic [fpba_pkg::SIZE_BITS-1:0] out_remaining
);
  import fpba_pkg::*;

  cap_t             tbl_r [NUM_BLOCKS];
  logic [IDX_W-1:0] rover_r;

  logic             func_r;
  logic [IDX_W-1:0] idx_r;
  cap_t             amt_r;

  logic [IDX_W-1:0] pos_r;
  logic [NB_W-1:0]  cnt_r;
  logic             found_r;
  logic [IDX_W-1:0] sel_r;
  cap_t             best_r;

  logic             valid_r;
  logic             granted_r;
  logic [IDX_W-1:0] chosen_r;
  cap_t             rem_r;

  logic [NB_W-1:0]  in_use;
  logic [NB_W-1:0]  pos_inc;
  logic [IDX_W-1:0] pos_next;
  logic [IDX_W-1:0] pos_start;
  cap_t             cap;
  logic             fits;
  logic             take;
  logic             load_ok;
  cap_t             alloc_rem;

  // Clamp the block count to the table depth
  assign in_use = (num_blocks > NB_W'(NUM_BLOCKS)) ? NB_W'(NUM_BLOCKS) : num_blocks;

  assign pos_start = (policy == POL_NEXT && NB_W'(rover_r) < in_use) ? rover_r : '0;
  assign pos_inc   = NB_W'(pos_r) + NB_W'(1);
  assign pos_next  = (pos_inc == in_use) ? '0 : pos_inc[IDX_W-1:0];

  assign cap  = tbl_r[pos_r];
  assign fits = (cap >= amt_r);
  assign take = fits && (!found_r ||
                         (policy == POL_BEST  && cap < best_r) ||
                         (policy == POL_WORST && cap > best_r));

  assign load_ok   = (NB_W'(idx_r) < NB_W'(NUM_BLOCKS));
  assign alloc_rem = best_r - amt_r;

  assign stat.in_alloc = (in_func == FUNC_ALLOC);
  assign stat.empty    = (in_use == '0);
  assign stat.stop     = fits && (policy == POL_FIRST || policy == POL_NEXT);
  assign stat.last     = (cnt_r == in_use - NB_W'(1));

  // Table and rover carry architectural reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        tbl_r[i] <= '0;
      end
      rover_r <= '0;
    end else if (cmd.commit) begin
      if (func_r == FUNC_LOAD) begin
        if (load_ok) begin
          tbl_r[idx_r] <= amt_r;
          rover_r      <= '0;
        end
      end else if (found_r) begin
        tbl_r[sel_r] <= alloc_rem;
        if (policy == POL_NEXT) begin
          rover_r <= sel_r;
        end
      end
    end
  end

  // Item capture and scan state
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r  <= in_func;
      idx_r   <= in_block_index;
      amt_r   <= in_amount;
      pos_r   <= pos_start;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.step) begin
      pos_r <= pos_next;
      cnt_r <= cnt_r + NB_W'(1);
      if (take) begin
        found_r <= 1'b1;
        sel_r   <= pos_r;
        best_r  <= cap;
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (func_r == FUNC_LOAD && load_ok) begin
        granted_r <= 1'b1;
        chosen_r  <= idx_r;
        rem_r     <= amt_r;
      end else if (func_r == FUNC_ALLOC && found_r) begin
        granted_r <= 1'b1;
        chosen_r  <= sel_r;
        rem_r     <= alloc_rem;
      end else begin
        granted_r <= 1'b0;
        chosen_r  <= '0;
        rem_r     <= '0;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_granted      = granted_r;
  assign out_chosen_block = chosen_r;
  assign out_remaining    = rem_r;

endmodule
